// File: sv/tae_pkg.sv
`default_nettype none

package tae_pkg;

    // Field widths.
    localparam int IN_W   = 32;
    localparam int X_W    = 28;
    localparam int COEF_W = 64;
    localparam int TOL_W  = 32;

    // Demand gains in Q6.24.
    localparam logic [29:0] GAIN_SURGE_ACC = 30'd6605203;
    localparam logic [29:0] GAIN_SURGE_VEL = 30'd90429194;
    localparam logic [29:0] GAIN_ROT_ACC   = 30'd620987378;
    localparam logic [29:0] GAIN_ROT_VEL   = 30'd117441;

    // Configuration register indexes.
    localparam logic [2:0] REG_CURVE_C0    = 3'd0;
    localparam logic [2:0] REG_CURVE_C1    = 3'd1;
    localparam logic [2:0] REG_CURVE_C2    = 3'd2;
    localparam logic [2:0] REG_CURVE_C3    = 3'd3;
    localparam logic [2:0] REG_ESC_FLOOR   = 3'd4;
    localparam logic [2:0] REG_ESC_CEILING = 3'd5;
    localparam logic [2:0] REG_ESC_START   = 3'd6;
    localparam logic [2:0] REG_THRUST_TOL  = 3'd7;

    // Status of the serial divider as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
        logic sat;
    } div_status_t;

    // Saturate a wide signed value to the signed 64-bit range.
    function automatic logic signed [63:0] sat64(input logic signed [77:0] v);
        logic signed [77:0] hi_lim;
        logic signed [77:0] lo_lim;
        hi_lim = $signed({15'd0, {63{1'b1}}});
        lo_lim = $signed({15'h7fff, {63{1'b0}}});
        if (v > hi_lim) begin
            sat64 = {1'b0, {63{1'b1}}};
        end else if (v < lo_lim) begin
            sat64 = {1'b1, {63{1'b0}}};
        end else begin
            sat64 = v[63:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: sv/tae_divider.sv
`default_nettype none

// Restoring divider: quotient of num * 2^32 / den, one bit per cycle.
// Quotient bits at or above bit 62 set the saturation flag instead.
module tae_divider
    import tae_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] num,
    input  wire logic [63:0] den,
    output div_status_t      status,
    output logic [61:0]      quotient
);

    logic [95:0] dvd_reg;
    logic [63:0] rem_reg;
    logic [61:0] q_reg;
    logic        sat_reg;
    logic [6:0]  cnt_reg;
    logic [63:0] den_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [64:0] trial;
    logic [64:0] diff;
    logic        fits;
    logic [63:0] rem_next;

    // One compare-and-subtract step.
    always_comb begin
        trial    = {rem_reg, dvd_reg[95]};
        diff     = trial - {1'b0, den_reg};
        fits     = (trial >= {1'b0, den_reg});
        rem_next = fits ? diff[63:0] : trial[63:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == 7'd0) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num, 32'd0};
            den_reg <= den;
            rem_reg <= 64'd0;
            q_reg   <= 62'd0;
            sat_reg <= 1'b0;
            cnt_reg <= 7'd95;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[94:0], 1'b0};
            rem_reg <= rem_next;
            q_reg   <= {q_reg[60:0], fits};
            if (fits && cnt_reg >= 7'd62) begin
                sat_reg <= 1'b1;
            end
            cnt_reg <= cnt_reg - 7'd1;
        end
    end

    assign status   = '{busy: busy_reg, done: done_reg, sat: sat_reg};
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: sv/thrust_allocation_esc_inverse_unit.sv
`default_nettype none

// Thrust allocation with Newton inversion of a cubic ESC curve.
// The input channel (s_valid/s_ready) takes one transaction of six signed
// Q16.16 accelerations and velocities. Three thrust demands are formed on one
// shared 33x33 multiplier, mixed to three motor thrusts, and each thrust is
// mapped to an ESC command by Newton steps on the configured cubic curve.
// The result channel (m_valid/m_ready) carries three Q12.16 ESC commands with
// clamp and unconverged masks; it sits in an output register, so a new input
// transaction can be taken while the previous result still waits.
// A motor needs no Newton step when the start value already meets the
// tolerance, and takes at most MAX_ITERATIONS = 16 Newton steps. A Newton
// step is made of the bit-serial divider plus five Horner steps.
// One item is worked on at a time; s_ready is high only while idle.
// The configuration port writes registers at once; it is to be used only
// while idle, and the block itself does not enforce that.
// Reset (aresetn low, synchronous) restores the default curve and bounds and
// empties the result register. A stalled receiver holds the result; the next
// item then finishes and waits until the output register frees up.
module thrust_allocation_esc_inverse_unit
    import tae_pkg::*;
#(
    parameter int MAX_ITERATIONS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [31:0] s_surge_accel,
    input  wire logic signed [31:0] s_pitch_accel,
    input  wire logic signed [31:0] s_yaw_accel,
    input  wire logic signed [31:0] s_surge_velocity,
    input  wire logic signed [31:0] s_pitch_rate,
    input  wire logic signed [31:0] s_yaw_rate,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [27:0]             m_esc_motor_a,
    output logic [27:0]             m_esc_motor_b,
    output logic [27:0]             m_esc_motor_c,
    output logic [2:0]              m_clamp_mask,
    output logic [2:0]              m_unconverged_mask
);

    localparam int IT_W = $clog2(MAX_ITERATIONS + 1);
    localparam logic [IT_W-1:0] IT_MAX = IT_W'(MAX_ITERATIONS);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_DEM_MUL    = 4'd1;
    localparam logic [3:0] S_DEM_ACC    = 4'd2;
    localparam logic [3:0] S_TARGET     = 4'd3;
    localparam logic [3:0] S_MOTOR      = 4'd4;
    localparam logic [3:0] S_MAC_LO     = 4'd5;
    localparam logic [3:0] S_MAC_HI     = 4'd6;
    localparam logic [3:0] S_MAC_SUM    = 4'd7;
    localparam logic [3:0] S_MAC_ADD    = 4'd8;
    localparam logic [3:0] S_ERR        = 4'd9;
    localparam logic [3:0] S_SLOPE_CHK  = 4'd10;
    localparam logic [3:0] S_DIV_WAIT   = 4'd11;
    localparam logic [3:0] S_MOTOR_DONE = 4'd12;
    localparam logic [3:0] S_OUTPUT     = 4'd13;

    // Configuration registers.
    logic signed [63:0] curve_c0_reg;
    logic signed [63:0] curve_c1_reg;
    logic signed [63:0] curve_c2_reg;
    logic signed [63:0] curve_c3_reg;
    logic [27:0]        esc_floor_reg;
    logic [27:0]        esc_ceiling_reg;
    logic [27:0]        esc_start_reg;
    logic [31:0]        tol_reg;

    // Sequencer and datapath registers.
    logic [3:0]         state_reg;
    logic [3:0]         state_next;
    logic signed [31:0] in_reg [0:5];
    logic [2:0]         dem_cnt_reg;
    logic signed [65:0] dacc_reg;
    logic signed [65:0] prod_reg;
    logic signed [63:0] t_reg [0:2];
    logic signed [63:0] target_reg [0:2];
    logic [1:0]         motor_reg;
    logic [27:0]        x_reg;
    logic [IT_W-1:0]    it_reg;
    logic signed [63:0] acc_reg;
    logic [1:0]         mac_cnt_reg;
    logic               slope_reg;
    logic [59:0]        mul_lo_reg;
    logic [59:0]        mul_hi_reg;
    logic [91:0]        full_reg;
    logic [63:0]        err_mag_reg;
    logic               err_neg_reg;
    logic               flip_reg;
    logic [27:0]        esc_reg [0:2];
    logic [2:0]         clamp_reg;
    logic [2:0]         unconv_reg;
    logic               m_valid_reg;

    // Combinational signals.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [2:0]         in_idx;
    logic [29:0]        gain;
    logic signed [65:0] dem_sum;
    logic signed [65:0] dem_round;
    logic [63:0]        acc_mag;
    logic signed [63:0] c3x3;
    logic signed [63:0] c2x2;
    logic signed [63:0] mac_coeff;
    logic               mac_last;
    logic [76:0]        mac_q;
    logic signed [77:0] mac_res;
    logic signed [63:0] mac_sat;
    logic signed [67:0] t25_4;
    logic signed [67:0] t25_5;
    logic signed [67:0] outer_a;
    logic signed [67:0] outer_c;
    logic signed [64:0] err_full;
    logic signed [63:0] err;
    logic [63:0]        err_mag;
    logic               converged;
    logic               div_start;
    div_status_t        div_status;
    logic [61:0]        div_q;
    logic [63:0]        step;
    logic signed [64:0] x_new;
    logic               below;
    logic               above;
    logic               s_accept;
    logic               out_load;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            curve_c0_reg    <= -64'sd17817366025784525;
            curve_c1_reg    <= 64'sd41602001557835;
            curve_c2_reg    <= -64'sd31806672368;
            curve_c3_reg    <= 64'sd7988260;
            esc_floor_reg   <= 28'd98304000;
            esc_ceiling_reg <= 28'd131072000;
            esc_start_reg   <= 28'd104857600;
            tol_reg         <= 32'd4295;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CURVE_C0:    curve_c0_reg    <= cfg_data;
                REG_CURVE_C1:    curve_c1_reg    <= cfg_data;
                REG_CURVE_C2:    curve_c2_reg    <= cfg_data;
                REG_CURVE_C3:    curve_c3_reg    <= cfg_data;
                REG_ESC_FLOOR:   esc_floor_reg   <= cfg_data[27:0];
                REG_ESC_CEILING: esc_ceiling_reg <= cfg_data[27:0];
                REG_ESC_START:   esc_start_reg   <= cfg_data[27:0];
                REG_THRUST_TOL:  tol_reg         <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // Derivative start coefficients, saturated.
    assign c3x3 = sat64(78'(curve_c3_reg) + (78'(curve_c3_reg) <<< 1));
    assign c2x2 = sat64(78'(curve_c2_reg) <<< 1);

    // Demand operand order: surge pair, pitch pair, yaw pair.
    always_comb begin
        in_idx = dem_cnt_reg[0] ? (3'd3 + {1'b0, dem_cnt_reg[2:1]})
                                : {1'b0, dem_cnt_reg[2:1]};
        case (dem_cnt_reg)
            3'd0:    gain = GAIN_SURGE_ACC;
            3'd1:    gain = GAIN_SURGE_VEL;
            default: gain = dem_cnt_reg[0] ? GAIN_ROT_VEL : GAIN_ROT_ACC;
        endcase
    end

    assign acc_mag = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;

    // Shared multiplier.
    always_comb begin
        case (state_reg)
            S_DEM_MUL: begin
                mul_a = 33'(in_reg[in_idx]);
                mul_b = $signed({3'd0, gain});
            end
            S_MAC_LO: begin
                mul_a = $signed({1'b0, acc_mag[31:0]});
                mul_b = $signed({5'd0, x_reg});
            end
            S_MAC_HI: begin
                mul_a = $signed({1'b0, acc_mag[63:32]});
                mul_b = $signed({5'd0, x_reg});
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Demand accumulation and rounding to Q.32.
    assign dem_sum   = dacc_reg + prod_reg;
    assign dem_round = (dem_sum + 66'sd128) >>> 8;

    // Motor mixing.
    assign t25_4   = (68'(t_reg[1]) <<< 4) + (68'(t_reg[1]) <<< 3) + 68'(t_reg[1]);
    assign t25_5   = (68'(t_reg[2]) <<< 4) + (68'(t_reg[2]) <<< 3) + 68'(t_reg[2]);
    assign outer_a = (68'(t_reg[0]) - t25_5 + t25_4 + 68'sd1) >>> 1;
    assign outer_c = (68'(t_reg[0]) - t25_5 - t25_4 + 68'sd1) >>> 1;

    // Horner step: sat64(floor(acc * x / 2^16) + coeff).
    always_comb begin
        if (slope_reg) begin
            mac_coeff = (mac_cnt_reg == 2'd0) ? c2x2 : curve_c1_reg;
            mac_last  = (mac_cnt_reg == 2'd1);
        end else begin
            case (mac_cnt_reg)
                2'd0:    mac_coeff = curve_c2_reg;
                2'd1:    mac_coeff = curve_c1_reg;
                default: mac_coeff = curve_c0_reg;
            endcase
            mac_last = (mac_cnt_reg == 2'd2);
        end
        mac_q = {1'b0, full_reg[91:16]}
              + {76'd0, (acc_reg[63] && (full_reg[15:0] != 16'd0))};
        if (acc_reg[63]) begin
            mac_res = 78'(mac_coeff) - $signed({1'b0, mac_q});
        end else begin
            mac_res = 78'(mac_coeff) + $signed({1'b0, mac_q});
        end
        mac_sat = sat64(mac_res);
    end

    // Thrust error against the motor target.
    assign err_full  = 65'(acc_reg >>> 16) - 65'(target_reg[motor_reg]);
    assign err       = err_full[63:0];
    assign err_mag   = err[63] ? (64'd0 - err) : err;
    assign converged = (err_mag <= {32'd0, tol_reg});

    // Newton update and bound check.
    always_comb begin
        step  = div_status.sat ? (64'd1 << 62) : {2'd0, div_q};
        x_new = flip_reg ? ($signed({37'd0, x_reg}) + $signed({1'b0, step}))
                         : ($signed({37'd0, x_reg}) - $signed({1'b0, step}));
        below = (x_new < $signed({37'd0, esc_floor_reg}));
        above = (x_new > $signed({37'd0, esc_ceiling_reg}));
    end

    assign div_start = (state_reg == S_SLOPE_CHK) && (acc_reg != 64'sd0);
    assign s_accept  = s_valid && s_ready;
    assign out_load  = (state_reg == S_OUTPUT) && (!m_valid_reg || m_ready);

    tae_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .num      (err_mag_reg),
        .den      (acc_mag),
        .status   (div_status),
        .quotient (div_q)
    );

    // Sequencer next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:       if (s_valid) state_next = S_DEM_MUL;
            S_DEM_MUL:    state_next = S_DEM_ACC;
            S_DEM_ACC:    state_next = (dem_cnt_reg == 3'd5) ? S_TARGET : S_DEM_MUL;
            S_TARGET:     state_next = S_MOTOR;
            S_MOTOR:      state_next = S_MAC_LO;
            S_MAC_LO:     state_next = S_MAC_HI;
            S_MAC_HI:     state_next = S_MAC_SUM;
            S_MAC_SUM:    state_next = S_MAC_ADD;
            S_MAC_ADD: begin
                if (!mac_last) begin
                    state_next = S_MAC_LO;
                end else begin
                    state_next = slope_reg ? S_SLOPE_CHK : S_ERR;
                end
            end
            S_ERR: begin
                if (converged || it_reg == IT_MAX) begin
                    state_next = S_MOTOR_DONE;
                end else begin
                    state_next = S_MAC_LO;
                end
            end
            S_SLOPE_CHK:  state_next = (acc_reg == 64'sd0) ? S_MOTOR_DONE : S_DIV_WAIT;
            S_DIV_WAIT: begin
                if (div_status.done) begin
                    state_next = (below || above) ? S_MOTOR_DONE : S_MAC_LO;
                end
            end
            S_MOTOR_DONE: state_next = (motor_reg == 2'd2) ? S_OUTPUT : S_MOTOR;
            S_OUTPUT:     if (out_load) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    in_reg[0] <= s_surge_accel;
                    in_reg[1] <= s_pitch_accel;
                    in_reg[2] <= s_yaw_accel;
                    in_reg[3] <= s_surge_velocity;
                    in_reg[4] <= s_pitch_rate;
                    in_reg[5] <= s_yaw_rate;
                end
                dem_cnt_reg <= 3'd0;
                dacc_reg    <= 66'sd0;
            end
            S_DEM_MUL: begin
                prod_reg <= mul_p;
            end
            S_DEM_ACC: begin
                if (dem_cnt_reg[0]) begin
                    t_reg[dem_cnt_reg[2:1]] <= dem_round[63:0];
                    dacc_reg <= 66'sd0;
                end else begin
                    dacc_reg <= dem_sum;
                end
                dem_cnt_reg <= dem_cnt_reg + 3'd1;
            end
            S_TARGET: begin
                target_reg[0] <= outer_a[63:0];
                target_reg[1] <= t25_5[63:0];
                target_reg[2] <= outer_c[63:0];
                motor_reg     <= 2'd0;
                clamp_reg     <= 3'd0;
                unconv_reg    <= 3'd0;
            end
            S_MOTOR: begin
                x_reg       <= esc_start_reg;
                it_reg      <= '0;
                acc_reg     <= curve_c3_reg;
                mac_cnt_reg <= 2'd0;
                slope_reg   <= 1'b0;
            end
            S_MAC_LO: begin
                mul_lo_reg <= mul_p[59:0];
            end
            S_MAC_HI: begin
                mul_hi_reg <= mul_p[59:0];
            end
            S_MAC_SUM: begin
                full_reg <= {mul_hi_reg, 32'd0} + {32'd0, mul_lo_reg};
            end
            S_MAC_ADD: begin
                acc_reg     <= mac_sat;
                mac_cnt_reg <= mac_cnt_reg + 2'd1;
            end
            S_ERR: begin
                err_mag_reg <= err_mag;
                err_neg_reg <= err[63];
                if (!converged && it_reg == IT_MAX) begin
                    unconv_reg[motor_reg] <= 1'b1;
                end
                // Derivative evaluation follows unless the motor is done.
                acc_reg     <= c3x3;
                mac_cnt_reg <= 2'd0;
                slope_reg   <= 1'b1;
            end
            S_SLOPE_CHK: begin
                flip_reg <= (err_neg_reg != acc_reg[63]);
                if (acc_reg == 64'sd0) begin
                    unconv_reg[motor_reg] <= 1'b1;
                end
            end
            S_DIV_WAIT: begin
                if (div_status.done) begin
                    if (below) begin
                        x_reg <= esc_floor_reg;
                        clamp_reg[motor_reg] <= 1'b1;
                    end else if (above) begin
                        x_reg <= esc_ceiling_reg;
                        clamp_reg[motor_reg] <= 1'b1;
                    end else begin
                        x_reg <= x_new[27:0];
                    end
                    it_reg      <= it_reg + IT_W'(1);
                    acc_reg     <= curve_c3_reg;
                    mac_cnt_reg <= 2'd0;
                    slope_reg   <= 1'b0;
                end
            end
            S_MOTOR_DONE: begin
                esc_reg[motor_reg] <= x_reg;
                motor_reg          <= motor_reg + 2'd1;
            end
            S_OUTPUT: begin
                if (out_load) begin
                    m_esc_motor_a      <= esc_reg[0];
                    m_esc_motor_b      <= esc_reg[1];
                    m_esc_motor_c      <= esc_reg[2];
                    m_clamp_mask       <= clamp_reg;
                    m_unconverged_mask <= unconv_reg;
                end
            end
            default: ;
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    // An accepted transaction makes the block busy on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("input accepted but block still ready");

    // The Newton step count never passes its cap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ERR) |-> (it_reg <= IT_MAX))
        else $error("iteration count beyond cap");

    // The divider never starts on a zero slope.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (acc_mag != 64'd0))
        else $error("divider started with zero divisor");

    // A result is loaded only into a free or draining output register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrote a pending transaction");

    // A clamped motor ends on one of the bounds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MOTOR_DONE && clamp_reg[motor_reg]) |->
            (x_reg == esc_floor_reg || x_reg == esc_ceiling_reg))
        else $error("clamped command not at a bound");

endmodule

`default_nettype wire
